[design/elsc_pkg.sv]
// Shared types and constants for the LOOK elevator scheduler.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package elsc_pkg;

	localparam int FLOORS  = 16;
	localparam int IDX_W   = $clog2(FLOORS);
	localparam int FLOOR_W = 5;
	localparam int TIME_W  = 16;
	localparam int CNT_W   = 5;
	localparam int DATA_W  = 32;

	localparam logic OP_REQUEST = 1'b0;
	localparam logic OP_TICK    = 1'b1;

	localparam logic CFG_START_FLOOR  = 1'b0;
	localparam logic CFG_CAR_CAPACITY = 1'b1;

	localparam logic [FLOOR_W-1:0] RESET_FLOOR    = FLOOR_W'(1);
	localparam logic [FLOOR_W-1:0] RESET_CAPACITY = FLOOR_W'(4);
	localparam logic [FLOOR_W-1:0] TOP_FLOOR      = FLOOR_W'(FLOORS);
	localparam logic [TIME_W-1:0]  TIME_MAX       = '1;

	typedef struct packed {
		logic [TIME_W-1:0]  call_time;
		logic [FLOOR_W-1:0] goal_floor;
		logic [FLOOR_W-1:0] origin_floor;
		logic               operation;
	} item_t;

	typedef struct packed {
		logic [CNT_W-1:0]   rider_count;
		logic [TIME_W-1:0]  tick_time;
		logic [FLOOR_W-1:0] car_floor;
	} result_t;

	typedef struct packed {
		logic  commit;
		item_t item;
	} step_t;

endpackage

[design/elsc_sched.sv]
// Scheduler state and the combinational next-state logic for one beat.
// Holds the per-floor tables, car position, direction, time and counts.
// Depends on elsc_pkg.
`timescale 1ns / 1ps

module elsc_sched (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic                         cfg_idx,
	input  logic [elsc_pkg::FLOOR_W-1:0] cfg_wdata,
	input  elsc_pkg::item_t              item,
	input  logic                         commit,
	output logic                         has_result,
	output elsc_pkg::result_t            result
);
	import elsc_pkg::*;

	logic [FLOORS-1:0]  waiting_q;
	logic [FLOORS-1:0]  riding_q;
	logic [FLOOR_W-1:0] goal_q [FLOORS];
	logic [TIME_W-1:0]  call_q [FLOORS];
	logic [FLOOR_W-1:0] pos_q;
	logic               up_q;
	logic [TIME_W-1:0]  tick_q;
	logic [CNT_W-1:0]   riders_q;
	logic [CNT_W-1:0]   undeliv_q;
	logic [FLOOR_W-1:0] cap_q;

	logic [FLOORS-1:0]  called;
	logic [FLOORS-1:0]  pick_vec;
	logic [FLOORS-1:0]  riding_mid;
	logic [FLOORS-1:0]  drop;
	logic [FLOORS-1:0]  waiting_n;
	logic [FLOORS-1:0]  riding_n;
	logic [FLOORS-1:0]  called_n;
	logic [CNT_W-1:0]   wcnt;
	logic [CNT_W-1:0]   wcnt_n;
	logic [CNT_W-1:0]   ndrop;
	logic [CNT_W-1:0]   riders_n;
	logic [IDX_W-1:0]   p_idx;
	logic [IDX_W-1:0]   o_idx;
	logic               p_in;
	logic               tick_active;
	logic               pickup;
	logic               room_n;
	logic               below;
	logic               above;
	logic               up_n;
	logic               move;
	logic               req_ok;
	logic [FLOOR_W-1:0] pos_n;

	always_comb begin
		tick_active = (item.operation == OP_TICK) && (undeliv_q != '0);
		p_in  = (pos_q >= FLOOR_W'(1)) && (pos_q <= TOP_FLOOR);
		p_idx = IDX_W'(pos_q - FLOOR_W'(1));
		o_idx = IDX_W'(item.origin_floor - FLOOR_W'(1));

		for (int i = 0; i < FLOORS; i++) begin
			called[i] = waiting_q[i] && (call_q[i] <= tick_q);
		end
		wcnt = CNT_W'($countones(called));

		pickup   = tick_active && p_in && called[p_idx] && ({1'b0, riders_q} < {1'b0, cap_q});
		pick_vec = '0;
		if (pickup) begin
			pick_vec[p_idx] = 1'b1;
		end
		riding_mid = riding_q | pick_vec;

		for (int i = 0; i < FLOORS; i++) begin
			drop[i] = riding_mid[i] && (goal_q[i] == pos_q);
		end
		ndrop     = CNT_W'($countones(drop));
		riding_n  = riding_mid & ~drop;
		waiting_n = waiting_q & ~pick_vec;
		called_n  = called & ~pick_vec;
		riders_n  = riders_q + CNT_W'(pickup) - ndrop;
		wcnt_n    = wcnt - CNT_W'(pickup);
		room_n    = riders_n < cap_q;

		below = 1'b0;
		above = 1'b0;
		for (int i = 0; i < FLOORS; i++) begin
			if ((riding_n[i] && goal_q[i] < pos_q)
					|| (FLOOR_W'(i + 1) < pos_q && called_n[i] && room_n)) begin
				below = 1'b1;
			end
			if ((riding_n[i] && goal_q[i] > pos_q)
					|| (FLOOR_W'(i + 1) > pos_q && called_n[i] && room_n)) begin
				above = 1'b1;
			end
		end

		up_n = up_q;
		if (!above && up_n) begin
			up_n = 1'b0;
		end
		if (!below && !up_n) begin
			up_n = 1'b1;
		end

		move  = (wcnt_n != '0) || (riders_n != '0);
		pos_n = pos_q;
		if (move) begin
			if (up_n) begin
				if (pos_q < TOP_FLOOR) begin
					pos_n = pos_q + FLOOR_W'(1);
				end
			end else begin
				if (pos_q > FLOOR_W'(1)) begin
					pos_n = pos_q - FLOOR_W'(1);
				end
			end
		end

		req_ok = (item.operation == OP_REQUEST)
			&& (item.origin_floor >= FLOOR_W'(1)) && (item.origin_floor <= TOP_FLOOR)
			&& (item.goal_floor >= FLOOR_W'(1)) && (item.goal_floor <= TOP_FLOOR)
			&& !waiting_q[o_idx] && !riding_q[o_idx];

		has_result = tick_active && ((tick_q == '0) || pickup || (drop != '0));
		result.car_floor   = pos_q;
		result.tick_time   = tick_q;
		result.rider_count = riders_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			waiting_q <= '0;
			riding_q  <= '0;
			for (int i = 0; i < FLOORS; i++) begin
				goal_q[i] <= '0;
			end
			pos_q     <= RESET_FLOOR;
			up_q      <= 1'b1;
			tick_q    <= '0;
			riders_q  <= '0;
			undeliv_q <= '0;
			cap_q     <= RESET_CAPACITY;
		end else if (commit && tick_active) begin
			waiting_q <= waiting_n;
			riding_q  <= riding_n;
			riders_q  <= riders_n;
			undeliv_q <= undeliv_q - ndrop;
			up_q      <= up_n;
			pos_q     <= pos_n;
			if (tick_q != TIME_MAX) begin
				tick_q <= tick_q + TIME_W'(1);
			end
		end else if (commit && req_ok) begin
			waiting_q[o_idx] <= 1'b1;
			goal_q[o_idx]    <= item.goal_floor;
			undeliv_q        <= undeliv_q + CNT_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_START_FLOOR: begin
					if (tick_q == '0) begin
						pos_q <= cfg_wdata;
					end
				end
				CFG_CAR_CAPACITY: begin
					cap_q <= cfg_wdata;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (commit && req_ok) begin
			call_q[o_idx] <= item.call_time;
		end
	end

`ifndef SYNTHESIS
	a_no_double_role: assert property (@(posedge clk) disable iff (!arst_n)
		(waiting_q & riding_q) == '0)
		else $error("floor both waiting and riding");

	a_riders_match: assert property (@(posedge clk) disable iff (!arst_n)
		riders_q == CNT_W'($countones(riding_q)))
		else $error("rider count out of step with riding flags");

	a_undeliv_match: assert property (@(posedge clk) disable iff (!arst_n)
		undeliv_q == CNT_W'($countones(riding_q)) + CNT_W'($countones(waiting_q)))
		else $error("undelivered count out of step with flags");

	a_tick_step: assert property (@(posedge clk) disable iff (!arst_n)
		tick_q != $past(tick_q) |-> tick_q == $past(tick_q) + TIME_W'(1))
		else $error("tick counter jumped");
`endif

endmodule

[design/elsc_out_buf.sv]
// Result register on the master side of the scheduler.
// Takes a result while the previous one is being taken.
// Depends on elsc_pkg.
`timescale 1ns / 1ps

module elsc_out_buf (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  elsc_pkg::result_t           in_res,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [elsc_pkg::DATA_W-1:0] m_axis_tdata
);
	import elsc_pkg::*;

	logic    valid_q;
	result_t res_q;

	assign in_ready      = !valid_q || m_axis_tready;
	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = DATA_W'(res_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			res_q <= in_res;
		end
	end

endmodule

[design/elevator_look_scheduler_core.sv]
// Top level of the single-car LOOK elevator scheduler.
// Instantiates elsc_sched and elsc_out_buf; depends on elsc_pkg.
//
//   Port group   Dir  Payload
//   s_axis_*     in   tuser: operation; tdata: origin_floor, goal_floor, call_time
//   m_axis_*     out  tdata: car_floor, tick_time, rider_count
//   cfg_*        in   cfg_idx 0 start_floor, 1 car_capacity; cfg_wdata 5 bits
//
// A beat lands in the input register and is retired from it, one beat per cycle unless
// a beat waits; the whole tick is evaluated by parallel per-floor compares in elsc_sched.
// A tick beat that reports a result waits in the input register while the result
// register is full and not being taken; other beats never wait.
// After reset the car stands at floor 1, capacity is 4, and all tables are empty.
`timescale 1ns / 1ps

module elevator_look_scheduler_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [elsc_pkg::DATA_W-1:0]  s_axis_tdata,  // origin_floor, goal_floor, call_time
	input  logic                         s_axis_tuser,  // operation
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [elsc_pkg::DATA_W-1:0]  m_axis_tdata,  // car_floor, tick_time, rider_count
	input  logic                         cfg_we,
	input  logic                         cfg_idx,
	input  logic [elsc_pkg::FLOOR_W-1:0] cfg_wdata
);
	import elsc_pkg::*;

	logic    valid_s1;
	item_t   item_s1;
	logic    has_result;
	result_t result;
	logic    buf_ready;
	logic    adv;

	assign adv           = valid_s1 && (!has_result || buf_ready);
	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.operation    <= s_axis_tuser;
			item_s1.origin_floor <= s_axis_tdata[FLOOR_W-1:0];
			item_s1.goal_floor   <= s_axis_tdata[2*FLOOR_W-1:FLOOR_W];
			item_s1.call_time    <= s_axis_tdata[2*FLOOR_W+TIME_W-1:2*FLOOR_W];
		end
	end

	elsc_sched u_sched (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_wdata  (cfg_wdata),
		.item       (item_s1),
		.commit     (adv),
		.has_result (has_result),
		.result     (result)
	);

	elsc_out_buf u_out_buf (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (valid_s1 && has_result),
		.in_ready      (buf_ready),
		.in_res        (result),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule
